/* hdl/bgd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bgd_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE     = 4'd0,
    REG_DC_WINDOW    = 4'd1,
    REG_LONG_PRESS   = 4'd2,
    REG_VLONG_PRESS  = 4'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [CFG_W-1:0] DC_WINDOW_RST   = 16'd400;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd800;
  localparam logic [CFG_W-1:0] VLONG_PRESS_RST = 16'd10000;

  typedef enum logic [1:0] {
    GS_IDLE    = 2'd0,
    GS_PRESSED = 2'd1,
    GS_LONG    = 2'd2
  } gesture_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_press_ms;
    logic [CFG_W-1:0] click_window_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] very_long_press_ms;
  } cfg_t;

  typedef struct packed {
    gesture_state_t    gesture_state;
    logic [TIME_W-1:0] press_start_ms;
    logic [TIME_W-1:0] first_release_ms;
    logic              awaiting_second;
  } gesture_ctx_t;

  typedef struct packed {
    logic single_click;
    logic double_click;
    logic modifier_held;
    logic reboot_request;
  } result_t;

endpackage

`default_nettype wire

/* hdl/bgd_poll_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bgd_poll_if;
  logic                       valid;
  logic                       ready;
  logic                       button_down;
  logic [bgd_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output button_down, output now_ms, input ready);
  modport sink   (input valid, input button_down, input now_ms, output ready);
endinterface

`default_nettype wire

/* hdl/bgd_gesture_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bgd_gesture_if;
  logic valid;
  logic ready;
  logic single_click;
  logic double_click;
  logic modifier_held;
  logic reboot_request;

  modport source (output valid, output single_click, output double_click,
                  output modifier_held, output reboot_request, input ready);
  modport sink   (input valid, input single_click, input double_click,
                  input modifier_held, input reboot_request, output ready);
endinterface

`default_nettype wire

/* hdl/bgd_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bgd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bgd_pkg::CFG_IDX_W-1:0] addr;
  logic [bgd_pkg::CFG_W-1:0]     data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* hdl/bgd_fsm.sv */
`timescale 1ns / 1ps
`default_nettype none

// Gesture state machine for one poll: next context and result from the
// current context, the registered poll and the settings.
module bgd_fsm (
  input  bgd_pkg::cfg_t                cfg,
  input  bgd_pkg::gesture_ctx_t        ctx,
  input  logic                         button_down,
  input  logic [bgd_pkg::TIME_W-1:0]   now_ms,
  output bgd_pkg::gesture_ctx_t        ctx_next,
  output bgd_pkg::result_t             result
);
  import bgd_pkg::*;

  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] since_release;
  logic              window_expired;
  logic              waiting;

  assign held          = now_ms - ctx.press_start_ms;
  assign since_release = now_ms - ctx.first_release_ms;
  assign window_expired = ctx.awaiting_second &&
                          (since_release > {{(TIME_W-CFG_W){1'b0}}, cfg.click_window_ms});
  assign waiting = ctx.awaiting_second && !window_expired;

  always_comb begin
    ctx_next                 = ctx;
    ctx_next.awaiting_second = waiting;
    result                   = '0;
    result.single_click      = window_expired;

    case (ctx.gesture_state)
      GS_IDLE: begin
        if (button_down) begin
          ctx_next.gesture_state  = GS_PRESSED;
          ctx_next.press_start_ms = now_ms;
        end
      end
      GS_PRESSED: begin
        if (!button_down) begin
          if (held > {{(TIME_W-CFG_W){1'b0}}, cfg.min_press_ms}) begin
            if (waiting) begin
              result.double_click      = 1'b1;
              ctx_next.awaiting_second = 1'b0;
            end else begin
              ctx_next.awaiting_second  = 1'b1;
              ctx_next.first_release_ms = now_ms;
            end
          end
          ctx_next.gesture_state = GS_IDLE;
        end else if (held >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms}) begin
          // long press drops any pending click
          ctx_next.awaiting_second = 1'b0;
          ctx_next.gesture_state   = GS_LONG;
        end
      end
      GS_LONG: begin
        if (!button_down) begin
          ctx_next.gesture_state = GS_IDLE;
        end else if (held >= {{(TIME_W-CFG_W){1'b0}}, cfg.very_long_press_ms}) begin
          result.reboot_request = 1'b1;
        end
      end
      default: begin
        ctx_next.gesture_state = GS_IDLE;
      end
    endcase

    result.modifier_held = (ctx_next.gesture_state == GS_LONG);
  end

endmodule

`default_nettype wire

/* hdl/button_gesture_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                          Role
// poll      in   button_down, now_ms[31:0]                        one button sample
// gesture   out  single_click, double_click, modifier_held,       one result per poll
//                reboot_request
// cfg       in   addr[3:0], data[15:0]                            settings write
//
// Two register stages: poll register, then result register; one poll per
// cycle sustained while gesture.ready holds. The gesture context
// updates as the result register loads, so the next poll sees it.
// A full result register that gesture does not take stalls the poll register,
// and a stalled poll register drops poll.ready. cfg is always ready. rst (synchronous) restores the
// default settings, idle state and empty stages.
module button_gesture_decoder (
  input  logic          clk,
  input  logic          rst,
  bgd_poll_if.sink      poll,
  bgd_gesture_if.source gesture,
  bgd_cfg_if.sink       cfg
);
  import bgd_pkg::*;

  cfg_t              settings;
  gesture_ctx_t      ctx;
  gesture_ctx_t      ctx_next;
  result_t           result_next;
  result_t           result;

  logic              poll_valid;
  logic              poll_down;
  logic [TIME_W-1:0] poll_now;
  logic              out_valid;
  logic              advance;

  assign advance     = poll_valid && (!out_valid || gesture.ready);
  assign poll.ready  = !poll_valid || advance;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      settings.min_press_ms       <= DEBOUNCE_RST;
      settings.click_window_ms    <= DC_WINDOW_RST;
      settings.long_press_ms      <= LONG_PRESS_RST;
      settings.very_long_press_ms <= VLONG_PRESS_RST;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_DEBOUNCE:    settings.min_press_ms       <= cfg.data;
        REG_DC_WINDOW:   settings.click_window_ms    <= cfg.data;
        REG_LONG_PRESS:  settings.long_press_ms      <= cfg.data;
        REG_VLONG_PRESS: settings.very_long_press_ms <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (poll.ready) begin
      poll_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      poll_down <= poll.button_down;
      poll_now  <= poll.now_ms;
    end
  end

  bgd_fsm u_fsm (
    .cfg         (settings),
    .ctx         (ctx),
    .button_down (poll_down),
    .now_ms      (poll_now),
    .ctx_next    (ctx_next),
    .result      (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx       <= '{gesture_state: GS_IDLE, press_start_ms: '0,
                     first_release_ms: '0, awaiting_second: 1'b0};
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        ctx       <= ctx_next;
        out_valid <= 1'b1;
      end else if (gesture.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign gesture.valid          = out_valid;
  assign gesture.single_click   = result.single_click;
  assign gesture.double_click   = result.double_click;
  assign gesture.modifier_held  = result.modifier_held;
  assign gesture.reboot_request = result.reboot_request;

endmodule

`default_nettype wire

/* tb/button_gesture_decoder_tb.sv */
`timescale 1ns / 1ps

module button_gesture_decoder_tb;
  import bgd_pkg::*;

  localparam int unsigned NUM_REGS          = 4;
  localparam logic [CFG_IDX_W-1:0] LAST_IDX = '1;
  localparam int unsigned NUM_PHASES        = 7;
  localparam int unsigned POLLS_PER_PHASE   = 250;
  localparam int unsigned SETTLE_CYCLES     = 6;
  localparam int unsigned CYCLE_LIMIT       = 500000;
  // idle percentages by stretch of the run: sink-heavy, sender-heavy, none
  localparam int unsigned STRETCH_LEN       = 600;

  // Tracks the decoder's gesture context and settings, predicts one result per poll.
  class gesture_tracker;
    localparam int unsigned MAX_REPORTS = 10;

    cfg_t              settings;
    gesture_state_t    gstate;
    logic [TIME_W-1:0] press_start;
    logic [TIME_W-1:0] first_release;
    bit                awaiting;
    result_t           expected_gestures[$];
    int unsigned       checked, mismatches;
    int unsigned       n_single, n_double, n_modifier, n_reboot;

    function new();
      settings.min_press_ms       = DEBOUNCE_RST;
      settings.click_window_ms    = DC_WINDOW_RST;
      settings.long_press_ms      = LONG_PRESS_RST;
      settings.very_long_press_ms = VLONG_PRESS_RST;
      gstate        = GS_IDLE;
      press_start   = '0;
      first_release = '0;
      awaiting      = 1'b0;
    endfunction

    function void write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_DEBOUNCE:    settings.min_press_ms       = val;
        REG_DC_WINDOW:   settings.click_window_ms    = val;
        REG_LONG_PRESS:  settings.long_press_ms      = val;
        REG_VLONG_PRESS: settings.very_long_press_ms = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_gestures.size();
    endfunction

    function void note_poll(logic down, logic [TIME_W-1:0] now_ms);
      logic [TIME_W-1:0] held;
      logic [TIME_W-1:0] since_release;
      result_t r;
      held          = now_ms - press_start;
      since_release = now_ms - first_release;
      r = '0;
      // window expiry is judged on the context from before this poll
      if (awaiting && since_release > TIME_W'(settings.click_window_ms)) begin
        awaiting = 1'b0;
        r.single_click = 1'b1;
      end
      case (gstate)
        GS_IDLE: begin
          if (down) begin
            gstate      = GS_PRESSED;
            press_start = now_ms;
          end
        end
        GS_PRESSED: begin
          if (!down) begin
            if (held > TIME_W'(settings.min_press_ms)) begin
              if (awaiting) begin
                r.double_click = 1'b1;
                awaiting       = 1'b0;
              end else begin
                awaiting      = 1'b1;
                first_release = now_ms;
              end
            end
            gstate = GS_IDLE;
          end else if (held >= TIME_W'(settings.long_press_ms)) begin
            awaiting = 1'b0;
            gstate   = GS_LONG;
          end
        end
        GS_LONG: begin
          if (!down)
            gstate = GS_IDLE;
          else if (held >= TIME_W'(settings.very_long_press_ms))
            r.reboot_request = 1'b1;
        end
        default: gstate = GS_IDLE;
      endcase
      r.modifier_held = (gstate == GS_LONG);
      n_single   += r.single_click;
      n_double   += r.double_click;
      n_modifier += r.modifier_held;
      n_reboot   += r.reboot_request;
      expected_gestures.push_back(r);
    endfunction

    function void flag(string what, logic want, logic got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d %s: expected %0b, got %0b", checked, what, want, got);
    endfunction

    function void check_gesture(result_t got);
      result_t want;
      if (expected_gestures.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result beat with no poll outstanding: got %4b", got);
        return;
      end
      want = expected_gestures.pop_front();
      if (got.single_click !== want.single_click)
        flag("single_click", want.single_click, got.single_click);
      if (got.double_click !== want.double_click)
        flag("double_click", want.double_click, got.double_click);
      if (got.modifier_held !== want.modifier_held)
        flag("modifier_held", want.modifier_held, got.modifier_held);
      if (got.reboot_request !== want.reboot_request)
        flag("reboot_request", want.reboot_request, got.reboot_request);
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bgd_poll_if    poll_bus();
  bgd_gesture_if gesture_bus();
  bgd_cfg_if     cfg_bus();

  button_gesture_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .poll    (poll_bus),
    .gesture (gesture_bus),
    .cfg     (cfg_bus)
  );

  gesture_tracker    tracker = new();
  int unsigned       polls_sent = 0;
  int unsigned       cycle_count = 0;
  cfg_t              cur;
  logic [TIME_W-1:0] now_t;

  always #4 clk = ~clk;

  function int unsigned sender_idle_pct();
    if (polls_sent < STRETCH_LEN) return 32;
    if (polls_sent < 2 * STRETCH_LEN) return 52;
    return 0;
  endfunction

  function int unsigned sink_idle_pct();
    if (polls_sent < STRETCH_LEN) return 52;
    if (polls_sent < 2 * STRETCH_LEN) return 32;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) gesture_bus.ready <= 1'b0;
    else gesture_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct());
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready)
        tracker.write_setting(cfg_bus.addr, cfg_bus.data);
      if (poll_bus.valid && poll_bus.ready)
        tracker.note_poll(poll_bus.button_down, poll_bus.now_ms);
      if (gesture_bus.valid && gesture_bus.ready)
        tracker.check_gesture({gesture_bus.single_click, gesture_bus.double_click,
                               gesture_bus.modifier_held, gesture_bus.reboot_request});
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending());
      $display("button_gesture_decoder test failed");
      $finish;
    end
  end

  task send_poll(logic down, logic [TIME_W-1:0] t);
    int unsigned gap_cycles;
    logic rdy;
    gap_cycles = 0;
    while ($urandom_range(0, 99) < sender_idle_pct()) gap_cycles++;
    if (gap_cycles != 0) begin
      poll_bus.valid <= 1'b0;
      repeat (gap_cycles) @(posedge clk);
    end
    poll_bus.valid       <= 1'b1;
    poll_bus.button_down <= down;
    poll_bus.now_ms      <= t;
    // ready is stable by the falling edge; the beat lands on the next rising edge
    do begin
      @(negedge clk);
      rdy = poll_bus.ready;
      @(posedge clk);
    end while (!rdy);
    polls_sent++;
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    logic rdy;
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= val;
    do begin
      @(negedge clk);
      rdy = cfg_bus.ready;
      @(posedge clk);
    end while (!rdy);
    cfg_bus.valid <= 1'b0;
  endtask

  task wait_for_results();
    poll_bus.valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task apply_settings(int unsigned phase);
    logic [CFG_W-1:0] d, w, l, v;
    case (phase)
      1: begin d = 16'd5; w = 16'd20; l = 16'd60; v = 16'd200; end
      2: begin d = '0; w = '0; l = '0; v = '0; end
      3: begin d = '1; w = '1; l = '1; v = '1; end
      4: begin
        d = CFG_W'($urandom);
        w = CFG_W'($urandom);
        l = CFG_W'($urandom);
        v = CFG_W'($urandom);
      end
      5: begin
        d = CFG_W'($urandom_range(0, 100));
        w = CFG_W'($urandom_range(0, 600));
        l = CFG_W'($urandom_range(32'(d), 2000));
        v = CFG_W'($urandom_range(32'(l), 5000));
      end
      default: begin
        d = DEBOUNCE_RST; w = DC_WINDOW_RST; l = LONG_PRESS_RST; v = VLONG_PRESS_RST;
      end
    endcase
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 32'(LAST_IDX))), CFG_W'($urandom));
    write_reg(REG_VLONG_PRESS, v);
    write_reg(REG_DEBOUNCE, d);
    write_reg(REG_LONG_PRESS, l);
    write_reg(REG_DC_WINDOW, w);
    if (phase == 3) write_reg(LAST_IDX, '0);
    cur.min_press_ms       = d;
    cur.click_window_ms    = w;
    cur.long_press_ms      = l;
    cur.very_long_press_ms = v;
  endtask

  // Press, optional polls while held, release, then a quiet gap sized around the window; or a burst of noise polls.
  task play_gesture();
    int unsigned pick, n_mid, n_idle, k, lo, hi;
    logic [TIME_W-1:0] hold, gap, press_t, rel_t;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise: random levels, occasional arbitrary jumps in time
      n_mid = $urandom_range(1, 4);
      for (k = 0; k < n_mid; k++) begin
        if ($urandom_range(0, 1)) now_t = $urandom;
        else now_t = now_t + $urandom_range(0, 3000);
        send_poll(1'($urandom_range(0, 1)), now_t);
      end
    end else begin
      if ($urandom_range(0, 19) == 0) now_t = '1 - $urandom_range(0, 70000);
      if (pick < 28) begin
        lo = 0; hi = 32'(cur.min_press_ms);
      end else if (pick < 62) begin
        lo = cur.min_press_ms + 1;
        hi = (cur.long_press_ms > lo) ? cur.long_press_ms - 1 : lo;
      end else if (pick < 84) begin
        lo = 32'(cur.long_press_ms);
        hi = (cur.very_long_press_ms > lo) ? cur.very_long_press_ms - 1 : lo + 50;
      end else begin
        lo = 32'(cur.very_long_press_ms);
        hi = lo + 3000;
      end
      hold = ($urandom_range(0, 3) == 0) ? ((pick < 28) ? hi : lo) : $urandom_range(lo, hi);
      press_t = now_t;
      send_poll(1'b1, press_t);
      if (pick < 62) begin
        n_mid = $urandom_range(0, 3);
        for (k = 1; k <= n_mid; k++) send_poll(1'b1, press_t + hold * k / (n_mid + 1));
        rel_t = press_t + hold;
      end else begin
        // held polls up to the hold time, some repeated past it
        n_mid = $urandom_range(0, 4);
        for (k = 1; k <= n_mid + 1; k++) send_poll(1'b1, press_t + hold * k / (n_mid + 1));
        rel_t = press_t + hold;
        n_mid = $urandom_range(0, 2);
        for (k = 0; k < n_mid; k++) begin
          rel_t = rel_t + $urandom_range(0, 20);
          send_poll(1'b1, rel_t);
        end
        rel_t = rel_t + $urandom_range(0, 20);
      end
      send_poll(1'b0, rel_t);
      k = $urandom_range(0, 9);
      if (k < 5) gap = $urandom_range(0, 32'(cur.click_window_ms));
      else if (k < 7) gap = cur.click_window_ms + $urandom_range(0, 1);
      else gap = cur.click_window_ms + 1
                 + $urandom_range(0, cur.click_window_ms + 500);
      n_idle = $urandom_range(0, 2);
      for (k = 1; k <= n_idle; k++) send_poll(1'b0, rel_t + gap * k / (n_idle + 1));
      if ($urandom_range(0, 9) < 3) send_poll(1'b0, rel_t + gap);
      now_t = rel_t + gap;
    end
  endtask

  initial begin
    int unsigned phase, target;
    poll_bus.valid       <= 1'b0;
    poll_bus.button_down <= 1'b0;
    poll_bus.now_ms      <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.addr         <= '0;
    cfg_bus.data         <= '0;
    cur.min_press_ms       = DEBOUNCE_RST;
    cur.click_window_ms    = DC_WINDOW_RST;
    cur.long_press_ms      = LONG_PRESS_RST;
    cur.very_long_press_ms = VLONG_PRESS_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings: debounce 50, window 400, long 800, very long 10000
    send_poll(1'b0, 32'd0);
    send_poll(1'b1, 32'd100);
    send_poll(1'b0, 32'd150);          // held equals debounce: ignored
    send_poll(1'b1, 32'd200);
    send_poll(1'b0, 32'd251);          // first click
    send_poll(1'b0, 32'd651);          // exactly at window: still pending
    send_poll(1'b0, 32'd652);          // single click
    send_poll(1'b1, 32'd1000);
    send_poll(1'b0, 32'd1100);
    send_poll(1'b1, 32'd1200);
    send_poll(1'b0, 32'd1300);         // double click
    send_poll(1'b1, 32'd2000);
    send_poll(1'b0, 32'd2060);
    send_poll(1'b1, 32'd2100);
    send_poll(1'b1, 32'd2900);         // pending click times out as the long press starts
    send_poll(1'b1, 32'd12099);
    send_poll(1'b1, 32'd12100);        // reboot, and held on the next poll
    send_poll(1'b1, 32'd13000);
    send_poll(1'b0, 32'd13100);
    send_poll(1'b1, 32'hFFFF_FFF0);    // press across the timestamp wrap
    send_poll(1'b0, 32'h0000_0030);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'h0000_0000);
    send_poll(1'b0, 32'h8000_0000);
    send_poll(1'b0, 32'h8000_0190);
    now_t = 32'h8000_0190 + 32'd1000;

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        wait_for_results();
        apply_settings(phase);
      end
      target = polls_sent + POLLS_PER_PHASE;
      while (polls_sent < target) play_gesture();
    end
    wait_for_results();

    $display("%0d polls checked across %0d register settings, unmapped writes included",
             tracker.checked, NUM_PHASES);
    $display("predicted %0d single, %0d double, %0d modifier-held, %0d reboot results",
             tracker.n_single, tracker.n_double, tracker.n_modifier, tracker.n_reboot);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("button_gesture_decoder test passed");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("button_gesture_decoder test failed");
    end
    $finish;
  end

endmodule
